// ===== hw/rtl/tsusq_pkg.sv =====
`default_nettype none

package tsusq_pkg;

   // sizing
   localparam int MAX_STRIPS_PER_SIDE = 1024;
   localparam int STRIP_W = 10;
   localparam int PTR_W = 11;
   localparam int CFG_W = 11;
   localparam int OP_W = 2;
   localparam int STAT_W = 3;
   localparam int TDATA_W = 16;
   localparam int IDX_W = $clog2(MAX_STRIPS_PER_SIDE);
   localparam int SLOT_AW = IDX_W + 1;
   localparam int SLOT_DEPTH = 2 * MAX_STRIPS_PER_SIDE;
   localparam int ENTRY_W = STRIP_W + 1;
   localparam int CAP_NEED_W = $clog2(MAX_STRIPS_PER_SIDE + 1);
   localparam int CMP_W = (CAP_NEED_W > PTR_W) ? CAP_NEED_W : PTR_W;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(768);
   localparam logic [PTR_W-1:0] PTR_MAX = {PTR_W{1'b1}};
   localparam logic [CMP_W-1:0] CAP_MAX = CMP_W'(MAX_STRIPS_PER_SIDE);
   localparam logic [SLOT_AW-1:0] SWEEP_LAST = SLOT_AW'(SLOT_DEPTH - 1);

   // request kinds
   localparam logic [OP_W-1:0] OP_ADD = 2'd0;
   localparam logic [OP_W-1:0] OP_USE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK = 3'd0,
      STAT_DUP = 3'd1,
      STAT_RANGE = 3'd2,
      STAT_FULL = 3'd3,
      STAT_PAST_END = 3'd4,
      STAT_EMPTY = 3'd5
   } tsusq_status_type;

   typedef enum logic [1:0] {
      S_SWEEP,
      S_IDLE,
      S_EXEC
   } tsusq_state_type;

   typedef struct packed {
      logic [STRIP_W-1:0] strip_out;
      logic               strip_valid;
      tsusq_status_type   status;
   } tsusq_result_type;

   // slot memory holds {live, strip} per queue position
   typedef struct packed {
      logic               wr_en;
      logic [SLOT_AW-1:0] wr_addr;
      logic [ENTRY_W-1:0] wr_data;
      logic               rd_en;
      logic [SLOT_AW-1:0] rd_addr;
   } tsusq_slot_req_type;

   // presence memory holds one bit per side and strip
   typedef struct packed {
      logic               wr_en;
      logic [SLOT_AW-1:0] wr_addr;
      logic               wr_data;
      logic               rd_en;
      logic [SLOT_AW-1:0] rd_addr;
   } tsusq_flag_req_type;

   // pointer step that sticks at its top value
   function automatic logic [PTR_W-1:0] bump_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_MAX) ? p : p + PTR_W'(1);
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tsusq_ram.sv =====
`default_nettype none

module tsusq_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tsusq_ctrl.sv =====
`default_nettype none

module tsusq_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [tsusq_pkg::OP_W-1:0]  req_op,
   input  wire logic                        req_side,
   input  wire logic [tsusq_pkg::STRIP_W-1:0] req_strip,
   input  wire logic [tsusq_pkg::CMP_W-1:0] cap,
   input  wire logic                        out_free,
   output logic                             res_load,
   output tsusq_pkg::tsusq_result_type      res,
   output tsusq_pkg::tsusq_slot_req_type    slot_req,
   input  wire logic [tsusq_pkg::ENTRY_W-1:0] slot_rdata,
   output tsusq_pkg::tsusq_flag_req_type    flag_req,
   input  wire logic                        flag_rdata
);

   import tsusq_pkg::*;

   tsusq_state_type    state_ff, state_in;
   logic [SLOT_AW-1:0] sweep_ff, sweep_in;
   logic [PTR_W-1:0]   fill_ff [2];
   logic [PTR_W-1:0]   fill_in [2];
   logic [PTR_W-1:0]   use_ff [2];
   logic [PTR_W-1:0]   use_in [2];
   logic [OP_W-1:0]    op_ff, op_in;
   logic               side_ff, side_in;
   logic [STRIP_W-1:0] strip_ff, strip_in;

   logic [PTR_W-1:0]   fill_cur;
   logic [PTR_W-1:0]   use_cur;
   logic               ent_live;
   logic [STRIP_W-1:0] ent_strip;

   assign fill_cur = fill_ff[side_ff];
   assign use_cur = use_ff[side_ff];
   assign ent_live = slot_rdata[ENTRY_W-1];
   assign ent_strip = slot_rdata[STRIP_W-1:0];

   // state and pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         sweep_ff <= '0;
         fill_ff[0] <= '0;
         fill_ff[1] <= '0;
         use_ff[0] <= '0;
         use_ff[1] <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         fill_ff[0] <= fill_in[0];
         fill_ff[1] <= fill_in[1];
         use_ff[0] <= use_in[0];
         use_ff[1] <= use_in[1];
      end
   end

   // captured word
   always_ff @(posedge clock) begin
      op_ff <= op_in;
      side_ff <= side_in;
      strip_ff <= strip_in;
   end

   // next state, memory accesses and result
   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      fill_in[0] = fill_ff[0];
      fill_in[1] = fill_ff[1];
      use_in[0] = use_ff[0];
      use_in[1] = use_ff[1];
      op_in = op_ff;
      side_in = side_ff;
      strip_in = strip_ff;
      slot_req = '0;
      flag_req = '0;
      req_ready = 1'b0;
      res_load = 1'b0;
      res = '{strip_out: '0, strip_valid: 1'b0, status: STAT_OK};

      unique case (state_ff)
         // wipe live and presence bits, one entry a cycle
         S_SWEEP: begin
            slot_req.wr_en = 1'b1;
            slot_req.wr_addr = sweep_ff;
            flag_req.wr_en = 1'b1;
            flag_req.wr_addr = sweep_ff;
            sweep_in = sweep_ff + SLOT_AW'(1);
            if (sweep_ff == SWEEP_LAST) begin
               state_in = S_IDLE;
            end
         end

         // take a word and start both memory reads
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in = req_op;
               side_in = req_side;
               strip_in = req_strip;
               slot_req.rd_en = 1'b1;
               slot_req.rd_addr = {req_side, IDX_W'(use_ff[req_side])};
               flag_req.rd_en = 1'b1;
               flag_req.rd_addr = {req_side, IDX_W'(req_strip)};
               state_in = S_EXEC;
            end
         end

         // decide, write back and hand the result over
         S_EXEC: begin
            if (out_free) begin
               res_load = 1'b1;
               state_in = S_IDLE;
               unique case (op_ff)
                  OP_ADD: begin
                     priority if (CMP_W'(strip_ff) >= cap) begin
                        res.status = STAT_RANGE;
                     end else if (CMP_W'(fill_cur) >= cap) begin
                        fill_in[side_ff] = bump_ptr(fill_cur);
                        res.status = STAT_FULL;
                     end else if (flag_rdata) begin
                        res.status = STAT_DUP;
                     end else begin
                        slot_req.wr_en = 1'b1;
                        slot_req.wr_addr = {side_ff, IDX_W'(fill_cur)};
                        slot_req.wr_data = {1'b1, strip_ff};
                        flag_req.wr_en = 1'b1;
                        flag_req.wr_addr = {side_ff, IDX_W'(strip_ff)};
                        flag_req.wr_data = 1'b1;
                        fill_in[side_ff] = bump_ptr(fill_cur);
                     end
                  end
                  OP_USE: begin
                     use_in[side_ff] = bump_ptr(use_cur);
                     priority if (CMP_W'(use_cur) >= cap) begin
                        res.status = STAT_PAST_END;
                     end else if (ent_live) begin
                        res.strip_out = ent_strip;
                        res.strip_valid = 1'b1;
                        slot_req.wr_en = 1'b1;
                        slot_req.wr_addr = {side_ff, IDX_W'(use_cur)};
                        slot_req.wr_data = {1'b0, ent_strip};
                        flag_req.wr_en = 1'b1;
                        flag_req.wr_addr = {side_ff, IDX_W'(ent_strip)};
                        flag_req.wr_data = 1'b0;
                     end else begin
                        res.status = STAT_EMPTY;
                     end
                  end
                  OP_CLEAR: begin
                     state_in = S_SWEEP;
                     sweep_in = '0;
                     fill_in[0] = '0;
                     fill_in[1] = '0;
                     use_in[0] = '0;
                     use_in[1] = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         default: begin
            state_in = S_SWEEP;
            sweep_in = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/two_sided_unique_strip_queue.sv =====
// Two deduplicating strip queues, one per detector side, sharing one datapath.
// Request channel (req_): tuser carries opcode and side, tdata the strip.
// Opcode add appends a strip unless it is out of range, the side is full or
// the strip already waits there; use hands out the next waiting strip once;
// clear empties both sides. Every request word yields exactly one response
// word on rsp_ with the strip handed out, its valid flag and a status code.
// On acceptance a request issues the reads of the slot memory and the
// presence memory; the exec state then decides and writes back once the
// output register is free. One request is in flight at a time, so a new
// request is not taken until the previous one has been decided.
// The response sits in an output register, so a new request is accepted
// while the previous response waits; if the receiver stalls, the request
// after that holds in its decide cycle until the register frees up.
// After reset, and after each clear, a sweep over all 2048 entries wipes
// the live and presence bits one entry per cycle; req_tready stays low meanwhile.
// csr_wr_en writes strips_per_side (reset 768), clamped to 1024 internally;
// write it only while no request is pending.
`default_nettype none

module two_sided_unique_strip_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [9:0] strip, rest zero
   input  wire logic [2:0]  req_tuser,   // [1:0] opcode, [2] side
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // [9:0] strip_out, rest zero
   output logic      [3:0]  rsp_tuser,   // [0] strip_valid, [3:1] status
   input  wire logic        csr_wr_en,
   input  wire logic [10:0] csr_wr_data  // [10:0] strips_per_side
);

   import tsusq_pkg::*;

   logic [CFG_W-1:0]   sps_ff, sps_in;
   logic [CMP_W-1:0]   cap;
   logic               rsp_valid_ff, rsp_valid_in;
   tsusq_result_type   rsp_res_ff, rsp_res_in;
   logic               out_free;
   logic               res_load;
   tsusq_result_type   res;
   tsusq_slot_req_type slot_req;
   tsusq_flag_req_type flag_req;
   logic [ENTRY_W-1:0] slot_rdata;
   logic               flag_rdata;

   // configuration register and capacity clamp
   assign sps_in = csr_wr_en ? csr_wr_data : sps_ff;
   assign cap = (CMP_W'(sps_ff) > CAP_MAX) ? CAP_MAX : CMP_W'(sps_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sps_ff <= CFG_RESET;
      end else begin
         sps_ff <= sps_in;
      end
   end

   // response output register
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = res_load || (rsp_valid_ff && !rsp_tready);
   assign rsp_res_in = res_load ? res : rsp_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(TDATA_W - STRIP_W){1'b0}}, rsp_res_ff.strip_out};
   assign rsp_tuser = {rsp_res_ff.status, rsp_res_ff.strip_valid};

   // sequencer
   tsusq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (req_tuser[1:0]),
      .req_side   (req_tuser[2]),
      .req_strip  (req_tdata[STRIP_W-1:0]),
      .cap        (cap),
      .out_free   (out_free),
      .res_load   (res_load),
      .res        (res),
      .slot_req   (slot_req),
      .slot_rdata (slot_rdata),
      .flag_req   (flag_req),
      .flag_rdata (flag_rdata)
   );

   // queue slots: live bit and strip
   tsusq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_req.wr_en),
      .wr_addr (slot_req.wr_addr),
      .wr_data (slot_req.wr_data),
      .rd_en   (slot_req.rd_en),
      .rd_addr (slot_req.rd_addr),
      .rd_data (slot_rdata)
   );

   // presence bits per side and strip
   tsusq_ram #(
      .WIDTH (1),
      .DEPTH (SLOT_DEPTH)
   ) u_flag_ram (
      .clock   (clock),
      .wr_en   (flag_req.wr_en),
      .wr_addr (flag_req.wr_addr),
      .wr_data (flag_req.wr_data),
      .rd_en   (flag_req.rd_en),
      .rd_addr (flag_req.rd_addr),
      .rd_data (flag_rdata)
   );

endmodule

`default_nettype wire
